// ----- design/pgpp_pkg.sv -----
// Package for the pixel to ground plane projection block.
// Holds field widths, register codes and reset values; depends on nothing.
package pgpp_pkg;

    localparam int PIXEL_BITS_DEF = 12;

    localparam int COEF_W   = 20;
    localparam int OFS_W    = 21;
    localparam int SCALE_W  = 24;
    localparam int CENTER_W = 12;
    localparam int COS_W    = 16;
    localparam int ROW_W    = 3 * COEF_W;
    localparam int MOUNT_W  = 3 * OFS_W;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;

    localparam int FRAC_W  = 30;
    localparam int LHS_SHIFT = 32;
    localparam int COORD_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RAY_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd6;

    localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd873813;
    localparam logic [CENTER_W-1:0] CENTER_RST = 12'd400;
    localparam logic [COS_W-1:0]    COS_RST    = 16'd655;

    localparam logic [FRAC_W-1:0] HALF_FRAC = 30'h2000_0000;

endpackage

// ----- design/pixel_to_ground_plane_projection.sv -----
// Top level of the pixel to ground plane projection block.
// Depends on pgpp_pkg for widths, register codes and reset values.
//
// Each camera pixel enters on the slave stream and one result leaves on the master
// stream. A new pixel can be taken in every clock cycle unless the master side stalls.
// Most of the pipeline is the restoring divider, which resolves one quotient bit per
// pipeline stage. A stall on the master side freezes the whole pipeline. The
// configuration registers may be written only while no transfer is in flight.
module pixel_to_ground_plane_projection #(
    parameter int PIXEL_BITS = pgpp_pkg::PIXEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pgpp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pgpp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pgpp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // From the lowest bit: pixel_col, pixel_row, zero fill.
    input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // From the lowest bit: map_col, map_row.
    output logic [2*pgpp_pkg::COORD_W-1:0]      m_tdata,
    // From the lowest bit: hit_ground, saturated.
    output logic [1:0]                          m_tuser
);
    import pgpp_pkg::*;

    localparam int P     = PIXEL_BITS;
    localparam int PW    = COEF_W + P + 1;
    localparam int BW    = P + 21;
    localparam int MW    = P + 20;
    localparam int CW    = MW + COS_W;
    localparam int H     = CW / 2;
    localparam int HW    = CW - H;
    localparam int HH_W  = 2 * HW;
    localparam int LL_W  = 2 * H;
    localparam int SQW   = 2 * CW;
    localparam int SW    = SQW + 2;
    localparam int NMW   = OFS_W + BW;
    localparam int NAW   = NMW - 1;
    localparam int NW    = NAW + 1;
    localparam int DW    = MW + 1;
    localparam int GW    = NW + 2;
    localparam int HIW   = GW - FRAC_W;
    localparam int HPW   = HIW + SCALE_W;
    localparam int LPW   = FRAC_W + SCALE_W;
    localparam int AW    = HPW + 1;
    localparam int XW    = AW + 2;

    localparam logic signed [XW-1:0] X_MAX = XW'(32767);
    localparam logic signed [XW-1:0] X_MIN = -XW'(32768);

    logic [ROW_W-1:0]    r_ray [0:2];
    logic [MOUNT_W-1:0]  r_mount;
    logic [SCALE_W-1:0]  r_scale;
    logic [CENTER_W-1:0] r_center;
    logic [COS_W-1:0]    r_cos;

    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray[0] <= '0;
            r_ray[1] <= '0;
            r_ray[2] <= '0;
            r_mount  <= '0;
            r_scale  <= SCALE_RST;
            r_center <= CENTER_RST;
            r_cos    <= COS_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RAY_X:  r_ray[0] <= pwdata[ROW_W-1:0];
                REG_RAY_Y:  r_ray[1] <= pwdata[ROW_W-1:0];
                REG_RAY_Z:  r_ray[2] <= pwdata[ROW_W-1:0];
                REG_MOUNT:  r_mount  <= pwdata[MOUNT_W-1:0];
                REG_SCALE:  r_scale  <= pwdata[SCALE_W-1:0];
                REG_CENTER: r_center <= pwdata[CENTER_W-1:0];
                REG_COS:    r_cos    <= pwdata[COS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RAY_X:  prdata = CFG_DATA_W'(r_ray[0]);
            REG_RAY_Y:  prdata = CFG_DATA_W'(r_ray[1]);
            REG_RAY_Z:  prdata = CFG_DATA_W'(r_ray[2]);
            REG_MOUNT:  prdata = CFG_DATA_W'(r_mount);
            REG_SCALE:  prdata = CFG_DATA_W'(r_scale);
            REG_CENTER: prdata = CFG_DATA_W'(r_center);
            REG_COS:    prdata = CFG_DATA_W'(r_cos);
            default:    prdata = '0;
        endcase
    end

    logic signed [OFS_W-1:0] tx, ty, tz;
    assign tx = r_mount[OFS_W-1:0];
    assign ty = r_mount[2*OFS_W-1:OFS_W];
    assign tz = r_mount[3*OFS_W-1:2*OFS_W];

    logic en;
    logic r_m_tvalid;
    assign en       = !r_m_tvalid || m_tready;
    assign s_tready = en;

    logic [P-1:0] col, row;
    assign col = s_tdata[P-1:0];
    assign row = s_tdata[2*P-1:P];

    // Stage 1: coefficient products.
    logic                 r_v1;
    logic signed [PW-1:0] r1_pc [0:2];
    logic signed [PW-1:0] r1_pr [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r1_pc[j] <= $signed(r_ray[j][COEF_W-1:0]) * $signed({1'b0, col});
                r1_pr[j] <= $signed(r_ray[j][2*COEF_W-1:COEF_W]) * $signed({1'b0, row});
            end
        end
    end

    // Stage 2: ray components.
    logic                 r_v2;
    logic signed [BW-1:0] r2_b [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r2_b[j] <= BW'(r1_pc[j]) + BW'(r1_pr[j])
                         + BW'($signed(r_ray[j][3*COEF_W-1:2*COEF_W]));
            end
        end
    end

    // Stage 3: scaled magnitudes and divider numerators.
    logic [MW-1:0] b_mag [0:2];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            b_mag[j] = r2_b[j][BW-1] ? MW'(-r2_b[j]) : MW'(r2_b[j]);
        end
    end

    logic                  r_v3;
    logic [CW-1:0]         r3_cm [0:3];
    logic signed [NMW-1:0] r3_num [0:1];
    logic [MW-1:0]         r3_d;
    logic                  r3_bzneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r3_cm[j] <= CW'(r_cos) * CW'(b_mag[j]);
            end
            r3_cm[3]  <= CW'(b_mag[2]);
            r3_num[0] <= tz * r2_b[0];
            r3_num[1] <= tz * r2_b[1];
            r3_d      <= b_mag[2];
            r3_bzneg  <= r2_b[2][BW-1];
        end
    end

    // Stage 4: partial products of the squares, divider operands.
    logic [NAW-1:0] num_mag [0:1];
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            num_mag[j] = r3_num[j][NMW-1] ? NAW'(-r3_num[j]) : NAW'(r3_num[j]);
        end
    end

    logic            r_v4;
    logic [HH_W-1:0] r4_hh [0:3];
    logic [CW-1:0]   r4_hl [0:3];
    logic [LL_W-1:0] r4_ll [0:3];
    logic [NW-1:0]   r4_n2 [0:1];
    logic            r4_neg [0:1];
    logic [DW-1:0]   r4_d2;
    logic            r4_bzneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r4_hh[l] <= HH_W'(r3_cm[l][CW-1:H]) * HH_W'(r3_cm[l][CW-1:H]);
                r4_hl[l] <= CW'(r3_cm[l][CW-1:H]) * CW'(r3_cm[l][H-1:0]);
                r4_ll[l] <= LL_W'(r3_cm[l][H-1:0]) * LL_W'(r3_cm[l][H-1:0]);
            end
            for (int j = 0; j < 2; j++) begin
                r4_n2[j]  <= {num_mag[j], 1'b0} + NW'(r3_d);
                r4_neg[j] <= r3_num[j][NMW-1];
            end
            r4_d2    <= {r3_d, 1'b0};
            r4_bzneg <= r3_bzneg;
        end
    end

    // Stage 5: full squares.
    logic           r_v5;
    logic [SQW-1:0] r5_sq [0:3];
    logic [NW-1:0]  r5_n2 [0:1];
    logic           r5_neg [0:1];
    logic [DW-1:0]  r5_d2;
    logic           r5_bzneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r5_sq[l] <= (SQW'(r4_hh[l]) << LL_W) + (SQW'(r4_hl[l]) << (H + 1))
                          + SQW'(r4_ll[l]);
            end
            r5_n2    <= r4_n2;
            r5_neg   <= r4_neg;
            r5_d2    <= r4_d2;
            r5_bzneg <= r4_bzneg;
        end
    end

    // Stage 6: downward test, and the first divider register.
    logic [SW-1:0] lhs, rhs;
    assign lhs = SW'(r5_sq[3]) << LHS_SHIFT;
    assign rhs = SW'(r5_sq[0]) + SW'(r5_sq[1]) + SW'(r5_sq[2]);

    logic          r_dv_v   [0:NW];
    logic          r_dv_hit [0:NW];
    logic [DW-1:0] r_dv_d2  [0:NW];
    logic [DW-1:0] r_dv_rem [0:NW][0:1];
    logic [NW-1:0] r_dv_q   [0:NW][0:1];
    logic [NW-1:0] r_dv_n2  [0:NW][0:1];
    logic          r_dv_neg [0:NW][0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_hit[0] <= r5_bzneg && (lhs >= rhs);
            r_dv_d2[0]  <= r5_d2;
            for (int j = 0; j < 2; j++) begin
                r_dv_rem[0][j] <= '0;
                r_dv_q[0][j]   <= '0;
                r_dv_n2[0][j]  <= r5_n2[j];
                r_dv_neg[0][j] <= r5_neg[j];
            end
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < NW; k++) begin : g_div
        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic [DW:0] trial;
            logic        ge;

            assign trial = {r_dv_rem[k][j], r_dv_n2[k][j][NW-1-k]};
            assign ge    = trial >= {1'b0, r_dv_d2[k]};

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[k+1][j] <= ge ? DW'(trial - {1'b0, r_dv_d2[k]}) : DW'(trial);
                    r_dv_q[k+1][j]   <= r_dv_q[k][j] | (NW'(ge) << (NW - 1 - k));
                    r_dv_n2[k+1][j]  <= r_dv_n2[k][j];
                    r_dv_neg[k+1][j] <= r_dv_neg[k][j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_d2[k+1]  <= r_dv_d2[k];
                r_dv_hit[k+1] <= r_dv_hit[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
    end

    // Tail stage 1: ground point.
    logic                 r_vt1, r_t1_hit;
    logic signed [GW-1:0] r_t1_g [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_hit  <= r_dv_hit[NW];
            r_t1_g[0] <= r_dv_neg[NW][0] ? GW'(tx) - GW'(r_dv_q[NW][0])
                                         : GW'(tx) + GW'(r_dv_q[NW][0]);
            r_t1_g[1] <= r_dv_neg[NW][1] ? GW'(ty) - GW'(r_dv_q[NW][1])
                                         : GW'(ty) + GW'(r_dv_q[NW][1]);
        end
    end

    // Tail stage 2: magnitude and sign.
    logic          r_vt2, r_t2_hit;
    logic [GW-1:0] r_t2_m   [0:1];
    logic          r_t2_pos [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2_hit <= r_t1_hit;
            for (int j = 0; j < 2; j++) begin
                r_t2_m[j]   <= r_t1_g[j][GW-1] ? GW'(-r_t1_g[j]) : GW'(r_t1_g[j]);
                r_t2_pos[j] <= !r_t1_g[j][GW-1] && (r_t1_g[j] != '0);
            end
        end
    end

    // Tail stage 3: scale products.
    logic           r_vt3, r_t3_hit;
    logic [HPW-1:0] r_t3_hp  [0:1];
    logic [LPW-1:0] r_t3_lp  [0:1];
    logic           r_t3_pos [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t3_hit <= r_t2_hit;
            for (int j = 0; j < 2; j++) begin
                r_t3_hp[j]  <= HPW'(r_t2_m[j][GW-1:FRAC_W]) * HPW'(r_scale);
                r_t3_lp[j]  <= LPW'(r_t2_m[j][FRAC_W-1:0]) * LPW'(r_scale);
                r_t3_pos[j] <= r_t2_pos[j];
            end
        end
    end

    // Tail stage 4: integer part and rounding bit.
    logic          r_vt4, r_t4_hit;
    logic [AW-1:0] r_t4_a   [0:1];
    logic          r_t4_rb  [0:1];
    logic          r_t4_pos [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t4_hit <= r_t3_hit;
            for (int j = 0; j < 2; j++) begin
                r_t4_a[j]   <= AW'(r_t3_hp[j]) + AW'(r_t3_lp[j][LPW-1:FRAC_W]);
                r_t4_rb[j]  <= r_t3_pos[j] ? (r_t3_lp[j][FRAC_W-1:0] > HALF_FRAC)
                                           : (r_t3_lp[j][FRAC_W-1:0] >= HALF_FRAC);
                r_t4_pos[j] <= r_t3_pos[j];
            end
        end
    end

    // Output stage: offset from the center, clamp.
    logic signed [XW-1:0]      x_val [0:1];
    logic signed [COORD_W-1:0] x_clip [0:1];
    logic                      x_sat [0:1];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            x_val[j] = r_t4_pos[j]
                ? XW'(r_center) - XW'(r_t4_a[j]) - XW'(r_t4_rb[j])
                : XW'(r_center) + XW'(r_t4_a[j]) + XW'(r_t4_rb[j]);
            x_sat[j] = (x_val[j] > X_MAX) || (x_val[j] < X_MIN);
            if (x_val[j] > X_MAX) begin
                x_clip[j] = COORD_W'(X_MAX);
            end else if (x_val[j] < X_MIN) begin
                x_clip[j] = COORD_W'(X_MIN);
            end else begin
                x_clip[j] = COORD_W'(x_val[j]);
            end
        end
    end

    logic [2*COORD_W-1:0] r_m_tdata;
    logic [1:0]           r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_t4_hit) begin
                r_m_tdata <= {x_clip[0], x_clip[1]};
                r_m_tuser <= {x_sat[0] || x_sat[1], 1'b1};
            end else begin
                r_m_tdata <= '0;
                r_m_tuser <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_v5       <= 1'b0;
            r_dv_v[0]  <= 1'b0;
            r_vt1      <= 1'b0;
            r_vt2      <= 1'b0;
            r_vt3      <= 1'b0;
            r_vt4      <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else if (en) begin
            r_v1       <= s_tvalid;
            r_v2       <= r_v1;
            r_v3       <= r_v2;
            r_v4       <= r_v3;
            r_v5       <= r_v4;
            r_dv_v[0]  <= r_v5;
            r_vt1      <= r_dv_v[NW];
            r_vt2      <= r_vt1;
            r_vt3      <= r_vt2;
            r_vt4      <= r_vt3;
            r_m_tvalid <= r_vt4;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

// ----- design/pgpp_checker.sv -----
// Port-level checks for the pixel to ground plane projection block.
// Depends on pgpp_pkg; bound to the top level at the end of this file.
module pgpp_checker #(
    parameter int PIXEL_BITS = pgpp_pkg::PIXEL_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [pgpp_pkg::CFG_ADDR_W-1:0]     paddr,
    input logic [pgpp_pkg::CFG_DATA_W-1:0]     pwdata,
    input logic [pgpp_pkg::CFG_DATA_W-1:0]     prdata,
    input logic                                pready,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((2*PIXEL_BITS+7)/8)*8-1:0]   s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [2*pgpp_pkg::COORD_W-1:0]      m_tdata,
    input logic [1:0]                          m_tuser
);
    import pgpp_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output transfer changed.");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("Rejected ray carries nonzero fields.");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[1] |->
            m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000 ||
            m_tdata[31:16] == 16'h7FFF || m_tdata[31:16] == 16'h8000)
        else $error("Saturation flag without a clipped coordinate.");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("Input taken while the output is stalled.");

endmodule

bind pixel_to_ground_plane_projection pgpp_checker #(.PIXEL_BITS(PIXEL_BITS)) u_pgpp_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking testbench for pixel_to_ground_plane_projection.
// Streams camera pixels through several register settings and checks each bird's-eye result
// against an in-bench projection model; depends on pgpp_pkg and the block's RTL.
module tb_top;
    import pgpp_pkg::*;

    localparam int PIX_W       = 12;
    localparam int LATENCY     = 11 + PIX_W + 42;
    localparam int WATCH_LIMIT = 4000;

    typedef struct {
        bit              hit;
        bit signed [15:0] map_col;
        bit signed [15:0] map_row;
        bit              sat;
    } t_ground_point;

    class t_projection_scoreboard;
        logic [ROW_W-1:0]    row_x, row_y, row_z;
        logic [MOUNT_W-1:0]  mount;
        logic [SCALE_W-1:0]  scale;
        logic [CENTER_W-1:0] center;
        logic [COS_W-1:0]    cos_min;
        t_ground_point       pending[$];
        int                  errors;
        int                  checked;
        int                  hits;
        int                  sats;

        function new();
            row_x = '0;
            row_y = '0;
            row_z = '0;
            mount = '0;
            scale = SCALE_RST;
            center = CENTER_RST;
            cos_min = COS_RST;
            errors = 0;
            checked = 0;
            hits = 0;
            sats = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function longint ray_dot(logic [ROW_W-1:0] r, longint col, longint rw);
            longint c0, c1, c2;
            c0 = longint'($signed(r[19:0]));
            c1 = longint'($signed(r[39:20]));
            c2 = longint'($signed(r[59:40]));
            return c0 * col + c1 * rw + c2;
        endfunction

        function longint ground_coord(longint t_own, longint t_z, longint b_own, longint b_z);
            longint num;
            longint unsigned n, d, q;
            bit neg;
            num = t_z * b_own;
            n = mag(num);
            d = mag(b_z);
            q = (2 * n + d) / (2 * d);
            neg = (num < 0) != (b_z < 0);
            return neg ? t_own + longint'(q) : t_own - longint'(q);
        endfunction

        function longint to_map(longint g, inout bit sat);
            logic [127:0] prod;
            logic [FRAC_W-1:0] f;
            longint a, x;
            prod = 128'(mag(g)) * 128'(scale);
            a = longint'(prod >> FRAC_W);
            f = prod[FRAC_W-1:0];
            if (g > 0)
                x = longint'(center) - a - ((f > HALF_FRAC) ? 1 : 0);
            else
                x = longint'(center) + a + ((f >= HALF_FRAC) ? 1 : 0);
            if (x > 32767) begin
                x = 32767;
                sat = 1;
            end
            if (x < -32768) begin
                x = -32768;
                sat = 1;
            end
            return x;
        endfunction

        function t_ground_point project_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] rw);
            t_ground_point p;
            longint bx, by, bz, tx, ty, tz, gx, gy;
            logic [127:0] lhs, rhs, cx, cy, cz;
            bit sat;
            bx = ray_dot(row_x, col, rw);
            by = ray_dot(row_y, col, rw);
            bz = ray_dot(row_z, col, rw);
            p = '{0, 0, 0, 0};
            if (bz < 0) begin
                lhs = (128'(mag(bz)) * 128'(mag(bz))) << LHS_SHIFT;
                cx = 128'(cos_min) * 128'(mag(bx));
                cy = 128'(cos_min) * 128'(mag(by));
                cz = 128'(cos_min) * 128'(mag(bz));
                rhs = cx * cx + cy * cy + cz * cz;
                if (lhs >= rhs) begin
                    tx = longint'($signed(mount[20:0]));
                    ty = longint'($signed(mount[41:21]));
                    tz = longint'($signed(mount[62:42]));
                    gx = ground_coord(tx, tz, bx, bz);
                    gy = ground_coord(ty, tz, by, bz);
                    sat = 0;
                    p.hit = 1;
                    p.map_col = 16'(to_map(gy, sat));
                    p.map_row = 16'(to_map(gx, sat));
                    p.sat = sat;
                end
            end
            return p;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] rw);
            pending.insert(pending.size(), project_pixel(col, rw));
        endfunction

        task check_result(logic [31:0] data, logic [1:0] user);
            t_ground_point e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result data=%h user=%b", data, user));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.hit) hits++;
            if (e.sat) sats++;
            if (user[0] !== e.hit)
                report($sformatf("hit_ground got %b exp %b", user[0], e.hit));
            if (user[1] !== e.sat)
                report($sformatf("saturated got %b exp %b", user[1], e.sat));
            if (data[15:0] !== e.map_col)
                report($sformatf("map_col got %0d exp %0d", $signed(data[15:0]), e.map_col));
            if (data[31:16] !== e.map_row)
                report($sformatf("map_row got %0d exp %0d", $signed(data[31:16]), e.map_row));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;
    logic s_tvalid = 0;
    logic s_tready;
    // From the lowest bit: pixel_col, pixel_row.
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    // From the lowest bit: map_col, map_row.
    logic [31:0] m_tdata;
    // From the lowest bit: hit_ground, saturated.
    logic [1:0] m_tuser;

    t_projection_scoreboard sb = new();
    int hold_off = 0;
    int idle_cycles = 0;
    int sent = 0;

    always #5 i_clk = ~i_clk;

    pixel_to_ground_plane_projection #(.PIXEL_BITS(PIX_W)) dut (.*);

    always begin
        int window, mode;
        mode = $urandom_range(0, 2);
        for (window = 0; window < 64; window++) begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                m_tready <= 0;
                hold_off--;
            end else if (mode == 0)
                m_tready <= 1;
            else if (mode == 1)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 1) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", sb.pending.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= CFG_ADDR_W'(idx) << 3;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_RAY_X:  sb.row_x = value[ROW_W-1:0];
            REG_RAY_Y:  sb.row_y = value[ROW_W-1:0];
            REG_RAY_Z:  sb.row_z = value[ROW_W-1:0];
            REG_MOUNT:  sb.mount = value[MOUNT_W-1:0];
            REG_SCALE:  sb.scale = value[SCALE_W-1:0];
            REG_CENTER: sb.center = value[CENTER_W-1:0];
            REG_COS:    sb.cos_min = value[COS_W-1:0];
            default: ;
        endcase
    endtask

    function logic [CFG_DATA_W-1:0] pack_row(int c_col, int c_row, int c_one);
        logic [19:0] a, b, c;
        a = c_col[19:0];
        b = c_row[19:0];
        c = c_one[19:0];
        return CFG_DATA_W'({c, b, a});
    endfunction

    function int srand(int lo, int hi);
        return int'($urandom_range(0, hi - lo)) + lo;
    endfunction

    task send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] rw);
        @(negedge i_clk);
        s_tvalid <= 1;
        s_tdata <= {rw, col};
        do @(posedge i_clk); while (!s_tready);
        sb.note_pixel(col, rw);
        sent++;
    endtask

    task drain_and_settle();
        @(negedge i_clk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task random_pixels(int count);
        int k, burst;
        burst = $urandom_range(1, 40);
        for (k = 0; k < count; k++) begin
            send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) begin
                    @(negedge i_clk);
                    s_tvalid <= 0;
                    repeat ($urandom_range(0, 12)) @(negedge i_clk);
                end
            end
        end
    endtask

    task plausible_setup(bit zero_cos);
        int zc;
        zc = -srand(1 << 14, (1 << 19) - 1);
        write_reg(REG_RAY_X, pack_row(srand(-64, 63), srand(-64, 63),
                                      srand(-(1 << 19), (1 << 19) - 1)));
        write_reg(REG_RAY_Y, pack_row(srand(-64, 63), srand(-64, 63),
                                      srand(-(1 << 19), (1 << 19) - 1)));
        write_reg(REG_RAY_Z, pack_row(srand(-16, 15), srand(-40, 40), zc));
        write_reg(REG_MOUNT, CFG_DATA_W'({21'(srand(0, 1 << 16)),
                                          21'(srand(-(1 << 15), 1 << 15)),
                                          21'(srand(-(1 << 15), 1 << 15))}));
        write_reg(REG_SCALE, CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                         ? $urandom_range(0, 24'hFFFFFF)
                                         : $urandom_range(0, 24'h0FFFFF)));
        write_reg(REG_CENTER, CFG_DATA_W'($urandom_range(0, 4095)));
        write_reg(REG_COS, CFG_DATA_W'(zero_cos ? 0 : $urandom_range(0, 20000)));
    endtask

    task extreme_setup(bit ones);
        logic [CFG_DATA_W-1:0] v;
        v = ones ? '1 : '0;
        write_reg(REG_RAY_X, v);
        write_reg(REG_RAY_Y, v);
        write_reg(REG_RAY_Z, v);
        write_reg(REG_MOUNT, v);
        write_reg(REG_SCALE, v);
        write_reg(REG_CENTER, v);
        write_reg(REG_COS, v);
    endtask

    initial begin
        int ph;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // With reset values every ray is zero and therefore rejected.
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        drain_and_settle();

        // A downward camera, then a nearly horizontal ray that saturates.
        write_reg(REG_RAY_X, pack_row(0, 16, -32768));
        write_reg(REG_RAY_Y, pack_row(16, 0, -32768));
        write_reg(REG_RAY_Z, pack_row(0, 0, -65536));
        write_reg(REG_MOUNT, CFG_DATA_W'({21'(24576), 21'(-8192), 21'(4096)}));
        write_reg(REG_SCALE, CFG_DATA_W'(SCALE_RST));
        write_reg(REG_CENTER, CFG_DATA_W'(CENTER_RST));
        write_reg(REG_COS, CFG_DATA_W'(COS_RST));
        send_pixel(0, 0);
        send_pixel(2048, 2048);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        drain_and_settle();
        write_reg(REG_COS, '0);
        send_pixel(1234, 3210);
        drain_and_settle();
        write_reg(REG_RAY_Z, pack_row(0, 0, -1));
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        drain_and_settle();
        write_reg(REG_COS, CFG_DATA_W'(16'hFFFF));
        send_pixel(0, 0);
        drain_and_settle();
        extreme_setup(1);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(1, 1);
        drain_and_settle();
        extreme_setup(0);
        send_pixel(4095, 4095);
        drain_and_settle();

        for (ph = 0; ph < 8; ph++) begin
            if (ph == 6)
                extreme_setup(1);
            else
                plausible_setup(ph == 3);
            if (ph == 2)
                hold_off = 300;
            random_pixels(165);
            drain_and_settle();
        end

        $display("Sent %0d pixels over fixed, random and extreme register sets; %0d checked,",
                 sent, sb.checked);
        $display("%0d of them on the ground and %0d clipped.", sb.hits, sb.sats);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- sim.f -----
design/pgpp_pkg.sv
design/pixel_to_ground_plane_projection.sv
design/pgpp_checker.sv
test/tb_top.sv
